// File: hw/rtl/lcc_pkg.sv
// shared types, constants and helper functions for the card number luhn classifier
`default_nettype none

package lcc_pkg;

  localparam int IN_W          = 54;
  localparam int DIGITS        = 16;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STAGES   = IN_W / BITS_PER_STEP;
  localparam int GROUPS        = 4;
  localparam int GROUP_SIZE    = DIGITS / GROUPS;
  localparam int PART_W        = 6;
  localparam int TOTAL_W       = 8;
  localparam int TOTAL_MAX     = 144;
  localparam int RADIX         = 10;

  // digit indices, digit 1 is the rightmost
  localparam int DIG13 = 12;
  localparam int DIG14 = 13;
  localparam int DIG15 = 14;
  localparam int DIG16 = 15;

  typedef logic [1:0] card_class_t;

  localparam card_class_t CLASS_INVALID    = 2'd0;
  localparam card_class_t CLASS_MASTERCARD = 2'd1;
  localparam card_class_t CLASS_AMEX       = 2'd2;
  localparam card_class_t CLASS_VISA       = 2'd3;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [IN_W-1:0]  rest;
  } conv_t;

  typedef struct packed {
    logic [GROUPS-1:0][PART_W-1:0] part;
    logic [3:0]                    dig13;
    logic [3:0]                    dig14;
    logic [3:0]                    dig15;
    logic [3:0]                    dig16;
  } luhn_t;

  typedef struct packed {
    card_class_t card_class;
    logic        checksum_ok;
  } result_t;

  // one double-dabble step: correct each digit, then shift in the next bit
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // digit sum of twice a decimal digit
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] dd;
    logic [4:0] r;
    dd = {d, 1'b0};
    r  = (dd >= 5'd10) ? (dd - 5'd9) : dd;
    return r[3:0];
  endfunction

  // true when the luhn total is a multiple of ten
  function automatic logic is_mult10(input logic [TOTAL_W-1:0] total);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= TOTAL_MAX / RADIX; k++) begin
      if (total == TOTAL_W'(k * RADIX)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/card_number_luhn_classifier_unit.sv
// top level of the card number luhn classifier pipeline
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_ready  card_value[53:0]
//   out      from block out_valid/out_ready  card_class[1:0], checksum_ok
//
// one request enters per cycle while the skid entry is not full;
// 27 conversion stages take two bits each (double dabble, 16 digits kept,
// so values above sixteen digits wrap modulo 10^16), then a luhn sum stage,
// a classify stage and the output register
// rst is synchronous and clears all valid bits; payload registers are not reset
// a stalled output holds in the output register, the next result in a skid
// entry; the whole pipeline freezes only while the skid entry is full
`default_nettype none

module card_number_luhn_classifier_unit
  import lcc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [IN_W-1:0] card_value,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output card_class_t          card_class,
  output logic                 checksum_ok
);

  // global advance enable, registered inside the output buffer
  logic    advance;

  // conversion chain, entry 0 is the raw request
  logic    conv_valid [CONV_STAGES+1];
  conv_t   conv_data  [CONV_STAGES+1];

  logic    luhn_valid;
  luhn_t   luhn_data;
  logic    class_valid;
  result_t class_data;
  result_t out_data;

  assign in_ready = advance;

  assign conv_valid[0]     = in_valid;
  assign conv_data[0].bcd  = '0;
  assign conv_data[0].rest = card_value;

  // binary to decimal, two bits per stage, msb first
  for (genvar s = 0; s < CONV_STAGES; s++) begin : g_conv
    lcc_bcd_stage u_bcd_stage (
      .clk         (clk),
      .rst         (rst),
      .en          (advance),
      .prev_valid  (conv_valid[s]),
      .prev_data   (conv_data[s]),
      .stage_valid (conv_valid[s+1]),
      .stage_data  (conv_data[s+1])
    );
  end

  // doubled-digit mapping and four partial sums
  lcc_luhn_sum u_luhn_sum (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .prev_valid  (conv_valid[CONV_STAGES]),
    .prev_bcd    (conv_data[CONV_STAGES].bcd),
    .stage_valid (luhn_valid),
    .stage_data  (luhn_data)
  );

  // total, mod-10 test and issuer prefix
  lcc_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .prev_valid  (luhn_valid),
    .prev_data   (luhn_data),
    .stage_valid (class_valid),
    .stage_data  (class_data)
  );

  // the last stage moves into the output side whenever the pipeline advances
  lcc_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && class_valid),
    .push_data (class_data),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign card_class  = out_data.card_class;
  assign checksum_ok = out_data.checksum_ok;

endmodule

`default_nettype wire

// File: hw/rtl/lcc_bcd_stage.sv
// one pipeline stage of the binary to decimal conversion
`default_nettype none

module lcc_bcd_stage
  import lcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  prev_valid,
  input  wire conv_t prev_data,
  output logic       stage_valid,
  output conv_t      stage_data
);

  conv_t step_data;

  always_comb begin
    step_data = prev_data;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      step_data.bcd  = dabble_step(step_data.bcd, step_data.rest[IN_W-1]);
      step_data.rest = {step_data.rest[IN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (en) begin
      stage_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_data <= step_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcc_luhn_sum.sv
// luhn digit mapping and partial sums over groups of four digits
`default_nettype none

module lcc_luhn_sum
  import lcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             prev_valid,
  input  wire logic [BCD_W-1:0] prev_bcd,
  output logic                  stage_valid,
  output luhn_t                 stage_data
);

  luhn_t            sum_data;
  logic [3:0]       mapped [DIGITS];

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      // odd index means an even digit position, counted from the right
      mapped[i] = (i % 2 == 1) ? luhn_double(prev_bcd[4*i +: 4]) : prev_bcd[4*i +: 4];
    end
    for (int g = 0; g < GROUPS; g++) begin
      sum_data.part[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        sum_data.part[g] = sum_data.part[g] + PART_W'(mapped[g*GROUP_SIZE + j]);
      end
    end
    sum_data.dig13 = prev_bcd[4*DIG13 +: 4];
    sum_data.dig14 = prev_bcd[4*DIG14 +: 4];
    sum_data.dig15 = prev_bcd[4*DIG15 +: 4];
    sum_data.dig16 = prev_bcd[4*DIG16 +: 4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (en) begin
      stage_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_data <= sum_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcc_classify.sv
// final luhn total, mod-10 check and issuer classification
`default_nettype none

module lcc_classify
  import lcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  prev_valid,
  input  wire luhn_t prev_data,
  output logic       stage_valid,
  output result_t    stage_data
);

  logic [TOTAL_W-1:0] total;
  result_t            res;

  always_comb begin
    total = '0;
    for (int g = 0; g < GROUPS; g++) begin
      total = total + TOTAL_W'(prev_data.part[g]);
    end
    res.checksum_ok = is_mult10(total);
    res.card_class  = CLASS_INVALID;
    if (res.checksum_ok) begin
      if (prev_data.dig16 == 4'd5) begin
        if (prev_data.dig15 >= 4'd1 && prev_data.dig15 <= 4'd5) begin
          res.card_class = CLASS_MASTERCARD;
        end
      end else if (prev_data.dig15 == 4'd3) begin
        if (prev_data.dig14 == 4'd4 || prev_data.dig14 == 4'd7) begin
          res.card_class = CLASS_AMEX;
        end
      end else if (prev_data.dig16 == 4'd4 || prev_data.dig13 == 4'd4) begin
        res.card_class = CLASS_VISA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (en) begin
      stage_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcc_out_buffer.sv
// output register with one skid entry, gives the pipeline a registered advance enable
`default_nettype none

module lcc_out_buffer
  import lcc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         advance,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    out_take;

  assign out_take = out_valid && out_ready;
  assign advance  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lcc_checker.sv
// port-level checks for the card number luhn classifier, bound to the top level
`default_nettype none

module lcc_checker
  import lcc_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire card_class_t     card_class,
  input wire logic            checksum_ok
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(card_class) && $stable(checksum_ok))
    else $error("result payload changed while stalled");

  // no issuer without a passing checksum
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !checksum_ok |-> card_class == CLASS_INVALID)
    else $error("issuer reported with failing checksum");

  // reset empties the output side
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // reset leaves the block able to take a request
  assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("request side blocked right after reset");

endmodule

bind card_number_luhn_classifier_unit lcc_checker u_lcc_checker (.*);

`default_nettype wire
